@@ rtl/twa_pkg.sv @@
// Shared types, codes and constants of the tick window aggregator.
package twa_pkg;

   localparam int unsigned TWA_PRICE_BITS = 24;
   localparam int unsigned TWA_SIZE_BITS  = 20;

   localparam int unsigned SYMBOL_W    = 32;
   localparam int unsigned STAMP_W     = 64;
   localparam int unsigned SUM_W       = 64;
   localparam int unsigned COUNT_W     = 48;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [KIND_W-1:0] KIND_SPREAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VWAP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OHLC   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_KIND   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_SYMBOL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_START = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_END   = 2'd3;

   localparam logic [SUM_W-1:0]   SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [STAMP_W-1:0] STAMP_ONES = '1;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SYMBOL_W-1:0] symbol;
      logic [STAMP_W-1:0]  win_start;
      logic [STAMP_W-1:0]  win_end;
   } twa_cfg_type;

   typedef struct packed {
      logic clear;
      logic sum_en;
      logic sum_force_max;
      logic ohlc_en;
   } twa_ctrl_type;

endpackage

@@ rtl/twa_if.sv @@
// Channel interfaces: tick requests, aggregate responses and register writes.
interface twa_req_if #(
   parameter int unsigned PRICE_BITS = twa_pkg::TWA_PRICE_BITS,
   parameter int unsigned SIZE_BITS  = twa_pkg::TWA_SIZE_BITS
);
   import twa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [SYMBOL_W-1:0]   symbol;
   logic [STAMP_W-1:0]    stamp;
   logic [PRICE_BITS-1:0] bid_px;
   logic [PRICE_BITS-1:0] ask_px;
   logic [SIZE_BITS-1:0]  bid_qty;
   logic [SIZE_BITS-1:0]  ask_qty;

   modport source (output valid, op, symbol, stamp, bid_px, ask_px, bid_qty, ask_qty,
                   input ready);
   modport sink (input valid, op, symbol, stamp, bid_px, ask_px, bid_qty, ask_qty,
                 output ready);
endinterface

interface twa_rsp_if #(
   parameter int unsigned PRICE_BITS = twa_pkg::TWA_PRICE_BITS
);
   import twa_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SUM_W-1:0]    acc_sum;
   logic [COUNT_W-1:0]         acc_count;
   logic                       ohlc_valid;
   logic [PRICE_BITS:0]        open_mid;
   logic [PRICE_BITS:0]        high_mid;
   logic [PRICE_BITS:0]        low_mid;
   logic [PRICE_BITS:0]        close_mid;
   logic [STAMP_W-1:0]         open_stamp;
   logic [STAMP_W-1:0]         close_stamp;

   modport source (output valid, acc_sum, acc_count, ohlc_valid, open_mid, high_mid,
                   low_mid, close_mid, open_stamp, close_stamp, input ready);
   modport sink (input valid, acc_sum, acc_count, ohlc_valid, open_mid, high_mid,
                 low_mid, close_mid, open_stamp, close_stamp, output ready);
endinterface

interface twa_csr_if;
   import twa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tick_window_aggregator_top.sv @@
// An accepted request reaches rsp via the input, decode and aggregate registers.
// Throughput: one request per cycle; input register, decode/multiply register and the
//   aggregate register form three stages, stalled only by rsp back-pressure.
// Reset (synchronous): registers return to their defaults (window end all ones) and
//   all accumulators are cleared; the pipeline empties.
// Top level of the tick window aggregator.
module tick_window_aggregator_top #(
   parameter int unsigned PRICE_BITS = twa_pkg::TWA_PRICE_BITS,
   parameter int unsigned SIZE_BITS  = twa_pkg::TWA_SIZE_BITS
) (
   input  logic      clock,
   input  logic      reset,
   twa_req_if.sink   req,
   twa_rsp_if.source rsp,
   twa_csr_if.sink   csr
);
   import twa_pkg::*;

   twa_cfg_type           cfg;
   logic                  dec_valid;
   logic                  dec_ready;
   twa_ctrl_type          dec_ctrl;
   logic [SUM_W-1:0]      dec_sum_delta;
   logic [SIZE_BITS:0]    dec_count_delta;
   logic [PRICE_BITS:0]   dec_mid;
   logic [STAMP_W-1:0]    dec_stamp;

   twa_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   twa_prep #(
      .PRICE_BITS (PRICE_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_prep (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .cfg             (cfg),
      .dec_ready       (dec_ready),
      .dec_valid       (dec_valid),
      .dec_ctrl        (dec_ctrl),
      .dec_sum_delta   (dec_sum_delta),
      .dec_count_delta (dec_count_delta),
      .dec_mid         (dec_mid),
      .dec_stamp       (dec_stamp)
   );

   twa_accum #(
      .PRICE_BITS (PRICE_BITS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .dec_valid       (dec_valid),
      .dec_ready       (dec_ready),
      .dec_ctrl        (dec_ctrl),
      .dec_sum_delta   (dec_sum_delta),
      .dec_count_delta (dec_count_delta),
      .dec_mid         (dec_mid),
      .dec_stamp       (dec_stamp),
      .rsp             (rsp)
   );

   // before any OHLC tick the bar is empty
   a_ohlc_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp.ohlc_valid |-> (rsp.open_stamp == STAMP_ONES) && (rsp.close_stamp == '0) &&
                          (rsp.high_mid == '0) && (rsp.low_mid == '0))
      else $error("OHLC fields set without an OHLC tick");

   a_ohlc_order: assert property (@(posedge clock) disable iff (reset)
      rsp.ohlc_valid |-> (rsp.low_mid <= rsp.high_mid) &&
                         (rsp.open_stamp <= rsp.close_stamp) &&
                         (rsp.open_mid <= rsp.high_mid) && (rsp.close_mid >= rsp.low_mid))
      else $error("OHLC bar out of order");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      dec_valid && dec_ready && dec_ctrl.clear |=>
         rsp.valid && (rsp.acc_sum == '0) && (rsp.acc_count == '0) && !rsp.ohlc_valid)
      else $error("clear request did not clear the aggregate");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      dec_valid && !dec_ready |-> rsp.valid && !rsp.ready)
      else $error("decode stage stalled without response back-pressure");

endmodule

@@ rtl/twa_csr.sv @@
// Query configuration registers.
module twa_csr (
   input  logic                clock,
   input  logic                reset,
   twa_csr_if.sink             csr,
   output twa_pkg::twa_cfg_type cfg
);
   import twa_pkg::*;

   twa_cfg_type cfg_ff;
   twa_cfg_type cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_QUERY_KIND:   cfg_in.kind      = csr.data[KIND_W-1:0];
            CSR_QUERY_SYMBOL: cfg_in.symbol    = csr.data[SYMBOL_W-1:0];
            CSR_WINDOW_START: cfg_in.win_start = csr.data[STAMP_W-1:0];
            CSR_WINDOW_END:   cfg_in.win_end   = csr.data[STAMP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind      <= KIND_SPREAD;
         cfg_ff.symbol    <= '0;
         cfg_ff.win_start <= '0;
         cfg_ff.win_end   <= STAMP_ONES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/twa_prep.sv @@
// Input register, tick filter and delta/product decode into the second stage.
module twa_prep #(
   parameter int unsigned PRICE_BITS = twa_pkg::TWA_PRICE_BITS,
   parameter int unsigned SIZE_BITS  = twa_pkg::TWA_SIZE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   twa_req_if.sink                       req,
   input  twa_pkg::twa_cfg_type          cfg,
   input  logic                          dec_ready,
   output logic                          dec_valid,
   output twa_pkg::twa_ctrl_type         dec_ctrl,
   output logic [twa_pkg::SUM_W-1:0]     dec_sum_delta,
   output logic [SIZE_BITS:0]            dec_count_delta,
   output logic [PRICE_BITS:0]           dec_mid,
   output logic [twa_pkg::STAMP_W-1:0]   dec_stamp
);
   import twa_pkg::*;

   localparam int unsigned MID_W  = PRICE_BITS + 1;
   localparam int unsigned VOL_W  = SIZE_BITS + 1;
   localparam int unsigned PROD_W = MID_W + VOL_W;
   localparam int unsigned EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [SYMBOL_W-1:0]   in_symbol_ff;
   logic [STAMP_W-1:0]    in_stamp_ff;
   logic [PRICE_BITS-1:0] in_bid_px_ff;
   logic [PRICE_BITS-1:0] in_ask_px_ff;
   logic [SIZE_BITS-1:0]  in_bid_qty_ff;
   logic [SIZE_BITS-1:0]  in_ask_qty_ff;

   logic                  dec_valid_ff;
   twa_ctrl_type          dec_ctrl_ff;
   twa_ctrl_type          dec_ctrl_in;
   logic [SUM_W-1:0]      dec_sum_delta_ff;
   logic [SUM_W-1:0]      dec_sum_delta_in;
   logic [VOL_W-1:0]      dec_count_delta_ff;
   logic [VOL_W-1:0]      dec_count_delta_in;
   logic [MID_W-1:0]      dec_mid_ff;
   logic [STAMP_W-1:0]    dec_stamp_ff;

   logic                  in_adv;
   logic                  dec_adv;
   logic                  match;
   logic [MID_W-1:0]      mid;
   logic [VOL_W-1:0]      vol;
   logic [PROD_W-1:0]     prod;
   logic [EXT_W-1:0]      prod_ext;
   logic                  prod_big;
   logic signed [MID_W-1:0] spread;
   logic [SUM_W-1:0]      spread_ext;

   assign dec_adv   = !dec_valid_ff || dec_ready;
   assign in_adv    = !in_valid_ff || dec_adv;
   assign req.ready = in_adv;

   always_comb begin
      match = (in_symbol_ff == cfg.symbol) && (in_stamp_ff >= cfg.win_start) &&
              (in_stamp_ff <= cfg.win_end);
      mid      = {1'b0, in_bid_px_ff} + {1'b0, in_ask_px_ff};
      vol      = {1'b0, in_bid_qty_ff} + {1'b0, in_ask_qty_ff};
      prod     = PROD_W'(mid) * PROD_W'(vol);
      prod_ext = EXT_W'(prod);
      // product beyond the signed sum range forces the sum to its maximum
      prod_big = |prod_ext[EXT_W-1:SUM_W-1];
      spread   = $signed({1'b0, in_ask_px_ff}) - $signed({1'b0, in_bid_px_ff});
      spread_ext = {{(SUM_W-MID_W){spread[MID_W-1]}}, spread};

      dec_ctrl_in.clear         = !in_op_ff;
      dec_ctrl_in.sum_en        = in_op_ff && match &&
                                  ((cfg.kind == KIND_SPREAD) ||
                                   ((cfg.kind == KIND_VWAP) && (vol != '0)));
      dec_ctrl_in.sum_force_max = (cfg.kind == KIND_VWAP) && prod_big;
      dec_ctrl_in.ohlc_en       = in_op_ff && match && (cfg.kind == KIND_OHLC);

      if (cfg.kind == KIND_VWAP) begin
         dec_sum_delta_in   = prod_ext[SUM_W-1:0];
         dec_count_delta_in = vol;
      end else begin
         dec_sum_delta_in   = spread_ext;
         dec_count_delta_in = VOL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         dec_valid_ff <= 1'b0;
      end else begin
         if (in_adv) begin
            in_valid_ff <= req.valid;
         end
         if (dec_adv) begin
            dec_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req.valid) begin
         in_op_ff      <= req.op;
         in_symbol_ff  <= req.symbol;
         in_stamp_ff   <= req.stamp;
         in_bid_px_ff  <= req.bid_px;
         in_ask_px_ff  <= req.ask_px;
         in_bid_qty_ff <= req.bid_qty;
         in_ask_qty_ff <= req.ask_qty;
      end
      if (dec_adv && in_valid_ff) begin
         dec_ctrl_ff        <= dec_ctrl_in;
         dec_sum_delta_ff   <= dec_sum_delta_in;
         dec_count_delta_ff <= dec_count_delta_in;
         dec_mid_ff         <= mid;
         dec_stamp_ff       <= in_stamp_ff;
      end
   end

   assign dec_valid       = dec_valid_ff;
   assign dec_ctrl        = dec_ctrl_ff;
   assign dec_sum_delta   = dec_sum_delta_ff;
   assign dec_count_delta = dec_count_delta_ff;
   assign dec_mid         = dec_mid_ff;
   assign dec_stamp       = dec_stamp_ff;

endmodule

@@ rtl/twa_accum.sv @@
// Aggregate state update; the state registers double as the response register.
module twa_accum #(
   parameter int unsigned PRICE_BITS = twa_pkg::TWA_PRICE_BITS,
   parameter int unsigned SIZE_BITS  = twa_pkg::TWA_SIZE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          dec_valid,
   output logic                          dec_ready,
   input  twa_pkg::twa_ctrl_type         dec_ctrl,
   input  logic [twa_pkg::SUM_W-1:0]     dec_sum_delta,
   input  logic [SIZE_BITS:0]            dec_count_delta,
   input  logic [PRICE_BITS:0]           dec_mid,
   input  logic [twa_pkg::STAMP_W-1:0]   dec_stamp,
   twa_rsp_if.source                     rsp
);
   import twa_pkg::*;

   localparam int unsigned MID_W    = PRICE_BITS + 1;
   localparam int unsigned SUM_WIDE_W = SUM_W + 1;
   localparam int unsigned CNT_WIDE_W = COUNT_W + 1;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic                  seen_ff;
   logic                  seen_in;
   logic [MID_W-1:0]      open_ff;
   logic [MID_W-1:0]      open_in;
   logic [MID_W-1:0]      high_ff;
   logic [MID_W-1:0]      high_in;
   logic [MID_W-1:0]      low_ff;
   logic [MID_W-1:0]      low_in;
   logic [MID_W-1:0]      close_ff;
   logic [MID_W-1:0]      close_in;
   logic [STAMP_W-1:0]    first_ff;
   logic [STAMP_W-1:0]    first_in;
   logic [STAMP_W-1:0]    last_ff;
   logic [STAMP_W-1:0]    last_in;

   logic                  out_take;
   logic                  fire;
   logic [SUM_WIDE_W-1:0] sum_wide;
   logic [SUM_W-1:0]      sum_sat;
   logic [CNT_WIDE_W-1:0] cnt_wide;
   logic [COUNT_W-1:0]    cnt_sat;

   assign out_take  = !out_valid_ff || rsp.ready;
   assign dec_ready = out_take;
   assign fire      = dec_valid && out_take;

   always_comb begin
      sum_wide = {sum_ff[SUM_W-1], sum_ff} + {dec_sum_delta[SUM_W-1], dec_sum_delta};
      if (dec_ctrl.sum_force_max) begin
         sum_sat = SUM_MAX;
      end else if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      cnt_wide = {1'b0, count_ff} + CNT_WIDE_W'(dec_count_delta);
      cnt_sat  = cnt_wide[COUNT_W] ? COUNT_MAX : cnt_wide[COUNT_W-1:0];

      out_valid_in = out_take ? dec_valid : out_valid_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      open_in  = open_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      close_in = close_ff;
      first_in = first_ff;
      last_in  = last_ff;

      if (fire) begin
         if (dec_ctrl.clear) begin
            sum_in   = '0;
            count_in = '0;
            seen_in  = 1'b0;
            open_in  = '0;
            high_in  = '0;
            low_in   = '0;
            close_in = '0;
            first_in = STAMP_ONES;
            last_in  = '0;
         end else begin
            if (dec_ctrl.sum_en) begin
               sum_in   = sum_sat;
               count_in = cnt_sat;
            end
            if (dec_ctrl.ohlc_en) begin
               if (!seen_ff) begin
                  seen_in  = 1'b1;
                  open_in  = dec_mid;
                  high_in  = dec_mid;
                  low_in   = dec_mid;
                  close_in = dec_mid;
                  first_in = dec_stamp;
                  last_in  = dec_stamp;
               end else begin
                  // equal stamps leave open and close alone
                  if (dec_stamp < first_ff) begin
                     first_in = dec_stamp;
                     open_in  = dec_mid;
                  end
                  if (dec_stamp > last_ff) begin
                     last_in  = dec_stamp;
                     close_in = dec_mid;
                  end
                  if (dec_mid > high_ff) begin
                     high_in = dec_mid;
                  end
                  if (dec_mid < low_ff) begin
                     low_in = dec_mid;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         open_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         close_ff     <= '0;
         first_ff     <= STAMP_ONES;
         last_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         open_ff      <= open_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         close_ff     <= close_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.acc_sum     = sum_ff;
   assign rsp.acc_count   = count_ff;
   assign rsp.ohlc_valid  = seen_ff;
   assign rsp.open_mid    = open_ff;
   assign rsp.high_mid    = high_ff;
   assign rsp.low_mid     = low_ff;
   assign rsp.close_mid   = close_ff;
   assign rsp.open_stamp  = first_ff;
   assign rsp.close_stamp = last_ff;

endmodule
